[rtl/slab_object_allocator_assert.svh]
// Assertion helpers for the allocator RTL (included by soa_dp).
`ifndef SLAB_OBJECT_ALLOCATOR_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SOA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, disabled during reset.
`define SOA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

[rtl/soa_pkg.sv]
`timescale 1ns / 1ps
package soa_pkg;

    localparam int SIZE_W      = 17;
    localparam int SLAB_W      = 9;
    localparam int SLOT_W      = 7;
    localparam int CLASS_W     = 4;
    localparam int STATUS_W    = 3;
    localparam int PS_W        = 5;
    localparam int CNT_W       = 8;
    localparam int MAX_SLOTS   = 128;
    localparam int NUM_CLASSES = 12;
    localparam int CHUNK_W     = 32;
    localparam int N_CHUNKS    = MAX_SLOTS / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(N_CHUNKS);
    localparam int BIT_IDX_W   = $clog2(CHUNK_W);
    localparam int CLS_IDX_W   = $clog2(NUM_CLASSES);
    localparam logic [PS_W-1:0] PAGE_SHIFT_RST = PS_W'(12);

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POOL_EXH  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ALREADY   = 3'd5;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] request_size;
        logic [SLAB_W-1:0] slab_id;
        logic [SLOT_W-1:0] slot;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLAB_W-1:0]   slab_out;
        logic [SLOT_W-1:0]   slot_out;
        logic [CLASS_W-1:0]  size_class;
    } out_item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [CNT_W-1:0]   total;
        logic [CNT_W-1:0]   free_cnt;
    } meta_t;

    typedef struct packed {
        logic                capture;
        logic                pick;
        logic                create;
        logic                free_pick;
        logic                rd_slab;
        logic                rd_walk;
        logic                scan;
        logic                acommit;
        logic                ftest;
        logic                fcommit;
        logic                wadv;
        logic                unlink;
        logic                push;
        logic                set_result;
        logic                emit;
        logic [STATUS_W-1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic size_zero;
        logic too_large;
        logic id_unknown;
        logic head_empty;
        logic pool_full;
        logic scan_last;
        logic found;
        logic free_bad;
        logic slab_full;
        logic walk_end;
        logic cur_is_id;
        logic out_busy;
    } stat_t;

    // Objects per slab for class c at the given page shift.
    function automatic logic [CNT_W-1:0] objects_for_class(
        input logic [CLASS_W-1:0] c,
        input logic [PS_W-1:0]    ps
    );
        logic [5:0] lim;
        logic [5:0] d;
        lim = 6'd5 + 6'(c);
        d   = 6'(ps) - lim;
        if (6'(ps) < lim)
            return CNT_W'(1);
        else if (d >= 6'd7)
            return CNT_W'(MAX_SLOTS);
        else
            return CNT_W'(1) << d;
    endfunction

endpackage

[rtl/soa_ram.sv]
`timescale 1ns / 1ps
module soa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/soa_ctrl.sv]
`timescale 1ns / 1ps
module soa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  soa_pkg::stat_t stat,
    output soa_pkg::cmd_t  cmd
);
    import soa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_PICK, S_READ, S_SCAN, S_ACOMMIT,
        S_FTEST, S_WALK, S_WCMP, S_PUSH, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.res_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_free)
                begin
                    if (stat.id_unknown)
                    begin
                        cmd.set_result = 1'b1;
                        cmd.res_status = ST_UNKNOWN;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.free_pick = 1'b1;
                        state_next    = S_READ;
                    end
                end
                else if (stat.size_zero)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_ZERO;
                    state_next     = S_DONE;
                end
                else if (stat.too_large)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_TOO_LARGE;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.pick   = 1'b1;
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (stat.head_empty && stat.pool_full)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_POOL_EXH;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.create = stat.head_empty;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_slab = 1'b1;
                state_next  = stat.is_free ? S_FTEST : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                    state_next = S_ACOMMIT;
            end
            S_ACOMMIT:
            begin
                cmd.set_result = 1'b1;
                cmd.acommit    = stat.found;
                cmd.res_status = stat.found ? ST_OK : ST_POOL_EXH;
                state_next     = S_DONE;
            end
            S_FTEST:
            begin
                cmd.ftest = 1'b1;
                if (stat.free_bad)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_ALREADY;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.fcommit = 1'b1;
                    if (stat.slab_full)
                        state_next = S_WALK;
                    else
                    begin
                        cmd.set_result = 1'b1;
                        state_next     = S_DONE;
                    end
                end
            end
            S_WALK:
            begin
                if (stat.walk_end)
                    state_next = S_PUSH;
                else
                begin
                    cmd.rd_walk = 1'b1;
                    state_next  = S_WCMP;
                end
            end
            S_WCMP:
            begin
                if (stat.cur_is_id)
                begin
                    cmd.unlink = 1'b1;
                    state_next = S_PUSH;
                end
                else
                begin
                    cmd.wadv   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_PUSH:
            begin
                cmd.push       = 1'b1;
                cmd.set_result = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);
endmodule

[rtl/soa_dp.sv]
`timescale 1ns / 1ps
module soa_dp #(
    parameter int POOL_SLABS = 512
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  soa_pkg::in_item_t                in_data,
    output soa_pkg::out_item_t               out_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             cfg_valid,
    input  logic [soa_pkg::PS_W-1:0]         cfg_data,
    input  soa_pkg::cmd_t                    cmd,
    output soa_pkg::stat_t                   stat
);
    import soa_pkg::*;
    `include "slab_object_allocator_assert.svh"

    localparam int IDX_W  = $clog2(POOL_SLABS);
    localparam int LINK_W = $clog2(POOL_SLABS + 1);
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_SLABS);

    in_item_t            req_reg;
    logic [PS_W-1:0]     page_shift_reg;
    logic [LINK_W-1:0]   partial_head_reg [NUM_CLASSES];
    logic [LINK_W-1:0]   full_head_reg [NUM_CLASSES];
    logic [LINK_W-1:0]   slabs_used_reg;
    logic [CLASS_W-1:0]  class_reg;
    logic [LINK_W-1:0]   slab_reg;
    logic [CHUNK_IDX_W-1:0] chunk_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic                found_reg;
    logic [LINK_W-1:0]   cur_reg;
    logic [LINK_W-1:0]   prev_reg;
    logic [LINK_W-1:0]   guard_reg;
    logic [STATUS_W-1:0] res_status_reg;
    out_item_t           out_data_reg;
    logic                out_valid_reg;

    // memory ports
    logic                 slab_we;
    logic [IDX_W-1:0]     slab_waddr;
    meta_t                meta_wdata, meta_rdata;
    logic [MAX_SLOTS-1:0] bm_wdata, bm_rdata;
    logic                 next_we;
    logic [IDX_W-1:0]     next_waddr, next_raddr;
    logic [LINK_W-1:0]    next_wdata, next_rdata;

    soa_ram #(.WIDTH($bits(meta_t)), .DEPTH(POOL_SLABS)) u_meta (
        .clk(clk), .we(slab_we), .waddr(slab_waddr), .wdata(meta_wdata),
        .re(cmd.rd_slab), .raddr(slab_reg[IDX_W-1:0]), .rdata(meta_rdata)
    );
    soa_ram #(.WIDTH(MAX_SLOTS), .DEPTH(POOL_SLABS)) u_bitmap (
        .clk(clk), .we(slab_we), .waddr(slab_waddr), .wdata(bm_wdata),
        .re(cmd.rd_slab), .raddr(slab_reg[IDX_W-1:0]), .rdata(bm_rdata)
    );
    soa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLABS)) u_next (
        .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .re(cmd.rd_slab | cmd.rd_walk), .raddr(next_raddr), .rdata(next_rdata)
    );

    // smallest class that fits the request
    logic [CLASS_W-1:0] cls_calc;
    logic               cls_none;
    always_comb
    begin
        cls_calc = '0;
        cls_none = 1'b1;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (req_reg.request_size <= SIZE_W'(32 << c))
            begin
                cls_calc = CLASS_W'(c);
                cls_none = 1'b0;
            end
        end
    end

    // first free slot within the current 32-slot chunk
    logic [CHUNK_W-1:0]   chunk_bits;
    logic                 chunk_hit;
    logic [BIT_IDX_W-1:0] chunk_pos;
    always_comb
    begin
        chunk_bits = ~bm_rdata[chunk_reg * CHUNK_W +: CHUNK_W];
        for (int j = 0; j < CHUNK_W; j++)
        begin
            if (CNT_W'(int'(chunk_reg) * CHUNK_W + j) >= meta_rdata.total)
                chunk_bits[j] = 1'b0;
        end
        chunk_hit = |chunk_bits;
        chunk_pos = '0;
        for (int j = CHUNK_W - 1; j >= 0; j--)
        begin
            if (chunk_bits[j])
                chunk_pos = BIT_IDX_W'(j);
        end
    end

    logic [CLASS_W-1:0] meta_cls;
    logic [CLS_IDX_W-1:0] cidx;
    logic [CNT_W-1:0]   free_dec;
    logic [CNT_W-1:0]   new_total;
    logic               slot_set;
    assign meta_cls  = (meta_rdata.cls >= CLASS_W'(NUM_CLASSES)) ? '0 : meta_rdata.cls;
    assign cidx      = CLS_IDX_W'(cmd.ftest ? meta_cls : class_reg);
    assign free_dec  = (meta_rdata.free_cnt != '0) ? meta_rdata.free_cnt - CNT_W'(1) : '0;
    assign new_total = objects_for_class(class_reg, page_shift_reg);
    assign slot_set  = bm_rdata[req_reg.slot];

    always_comb
    begin
        slab_we    = 1'b0;
        slab_waddr = slab_reg[IDX_W-1:0];
        meta_wdata = meta_rdata;
        bm_wdata   = bm_rdata;
        next_we    = 1'b0;
        next_waddr = slab_reg[IDX_W-1:0];
        next_wdata = partial_head_reg[cidx];
        next_raddr = cmd.rd_walk ? cur_reg[IDX_W-1:0] : slab_reg[IDX_W-1:0];
        if (cmd.create)
        begin
            slab_we    = 1'b1;
            slab_waddr = slabs_used_reg[IDX_W-1:0];
            meta_wdata = '{cls: class_reg, total: new_total, free_cnt: new_total};
            bm_wdata   = '0;
            next_we    = 1'b1;
            next_waddr = slabs_used_reg[IDX_W-1:0];
        end
        else if (cmd.acommit)
        begin
            slab_we             = 1'b1;
            meta_wdata.free_cnt = free_dec;
            bm_wdata[idx_reg]   = 1'b1;
            // slab went full: move it to the full list
            if (free_dec == '0)
            begin
                next_we    = 1'b1;
                next_wdata = full_head_reg[cidx];
            end
        end
        else if (cmd.fcommit)
        begin
            slab_we                = 1'b1;
            meta_wdata.free_cnt    = meta_rdata.free_cnt + CNT_W'(1);
            bm_wdata[req_reg.slot] = 1'b0;
        end
        else if (cmd.unlink)
        begin
            next_we    = (prev_reg != LINK_NONE);
            next_waddr = prev_reg[IDX_W-1:0];
            next_wdata = next_rdata;
        end
        else if (cmd.push)
        begin
            next_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg <= PAGE_SHIFT_RST;
            slabs_used_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                partial_head_reg[c] <= LINK_NONE;
                full_head_reg[c]    <= LINK_NONE;
            end
        end
        else
        begin
            if (cfg_valid)
                page_shift_reg <= cfg_data;
            if (cmd.create)
            begin
                partial_head_reg[cidx] <= slabs_used_reg;
                slabs_used_reg         <= slabs_used_reg + LINK_W'(1);
            end
            if (cmd.acommit && free_dec == '0)
            begin
                partial_head_reg[cidx] <= next_rdata;
                full_head_reg[cidx]    <= slab_reg;
            end
            if (cmd.unlink && prev_reg == LINK_NONE)
                full_head_reg[cidx] <= next_rdata;
            if (cmd.push)
                partial_head_reg[cidx] <= slab_reg;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= in_data;
            chunk_reg <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.pick)
        begin
            class_reg <= cls_calc;
            slab_reg  <= partial_head_reg[CLS_IDX_W'(cls_calc)];
        end
        if (cmd.create)
            slab_reg <= slabs_used_reg;
        if (cmd.free_pick)
            slab_reg <= LINK_W'(req_reg.slab_id);
        if (cmd.scan)
        begin
            chunk_reg <= chunk_reg + CHUNK_IDX_W'(1);
            if (!found_reg && chunk_hit)
            begin
                found_reg <= 1'b1;
                idx_reg   <= {chunk_reg, chunk_pos};
            end
        end
        if (cmd.ftest)
            class_reg <= meta_cls;
        if (cmd.fcommit)
        begin
            cur_reg   <= full_head_reg[cidx];
            prev_reg  <= LINK_NONE;
            guard_reg <= '0;
        end
        if (cmd.wadv)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= next_rdata;
            guard_reg <= guard_reg + LINK_W'(1);
        end
        if (cmd.set_result)
            res_status_reg <= cmd.res_status;
        if (cmd.emit)
        begin
            out_data_reg.status <= res_status_reg;
            if (res_status_reg == ST_ZERO || res_status_reg == ST_TOO_LARGE ||
                res_status_reg == ST_UNKNOWN)
            begin
                out_data_reg.slab_out   <= '0;
                out_data_reg.slot_out   <= '0;
                out_data_reg.size_class <= '0;
            end
            else if (res_status_reg == ST_POOL_EXH)
            begin
                out_data_reg.slab_out   <= '0;
                out_data_reg.slot_out   <= '0;
                out_data_reg.size_class <= class_reg;
            end
            else if (req_reg.op)
            begin
                out_data_reg.slab_out   <= req_reg.slab_id;
                out_data_reg.slot_out   <= req_reg.slot;
                out_data_reg.size_class <= class_reg;
            end
            else
            begin
                out_data_reg.slab_out   <= SLAB_W'(slab_reg);
                out_data_reg.slot_out   <= idx_reg;
                out_data_reg.size_class <= class_reg;
            end
        end
    end

    always_comb
    begin
        stat            = '0;
        stat.is_free    = req_reg.op;
        stat.size_zero  = (req_reg.request_size == '0);
        stat.too_large  = cls_none;
        stat.id_unknown = (32'(req_reg.slab_id) >= 32'(slabs_used_reg));
        stat.head_empty = (slab_reg >= LINK_NONE);
        stat.pool_full  = (slabs_used_reg >= LINK_NONE);
        stat.scan_last  = (chunk_reg == CHUNK_IDX_W'(N_CHUNKS - 1));
        stat.found      = found_reg;
        stat.free_bad   = (CNT_W'(req_reg.slot) >= meta_rdata.total) || !slot_set;
        stat.slab_full  = (meta_rdata.free_cnt == '0);
        stat.walk_end   = (cur_reg >= LINK_NONE) || (guard_reg >= LINK_NONE);
        stat.cur_is_id  = (cur_reg == slab_reg);
        stat.out_busy   = out_valid_reg && out_stall;
    end

    assign out_data  = out_data_reg;
    assign out_valid = out_valid_reg;

    `SOA_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, slabs_used_reg <= LINK_NONE)
    `SOA_ASSERT_IMP(a_create_room, clk, rst_n, cmd.create, slabs_used_reg < LINK_NONE)
    `SOA_ASSERT_IMP(a_commit_live, clk, rst_n, cmd.acommit, slab_reg < slabs_used_reg)
    `SOA_ASSERT_NXT(a_emit_shows, clk, rst_n, cmd.emit, out_valid_reg)
endmodule

[rtl/slab_object_allocator.sv]
// Allocate steps: decode, pick, read, four 32-slot bitmap scan steps, commit, output;
// early rejects go from decode straight to output; frees read, test, then output.
// A free into a full slab also walks the full list (walk, compare per slab) and pushes.
// One item at a time: the next transfer is taken after the result loads, once back in idle.
// Reset: all lists empty, no slabs in use, page_shift 12; slab memories are not cleared.
`timescale 1ns / 1ps
module slab_object_allocator #(
    parameter int POOL_SLABS = 512
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  soa_pkg::in_item_t        in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output soa_pkg::out_item_t       out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [soa_pkg::PS_W-1:0] cfg_data
);
    import soa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    soa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .stat(stat), .cmd(cmd)
    );

    soa_dp #(.POOL_SLABS(POOL_SLABS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .out_data(out_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data), .cmd(cmd), .stat(stat)
    );

    assign cfg_ready = 1'b1;
endmodule
